[src/xs128_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the xoshiro128** generator.
// No dependencies; imported by every module of the block.
package xs128_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [3:0][31:0]  words_t;

  // Result handed from the sequencer to the output stage
  typedef struct packed {
    logic   valid;
    word_t  value;
    words_t words;
  } res_t;

  localparam logic [1:0] MODE_GEN  = 2'd0;
  localparam logic [1:0] MODE_SEED = 2'd1;
  localparam logic [1:0] MODE_LOAD = 2'd2;

  localparam word_t SEED_MULT = 32'd1812433253;
  localparam word_t GEN_MUL1  = 32'd5;
  localparam word_t GEN_MUL2  = 32'd9;

  localparam int unsigned ROT_OUT   = 7;
  localparam int unsigned ROT_STATE = 11;
  localparam int unsigned SHL_STATE = 9;
  localparam int unsigned SEED_SHR  = 30;

  localparam word_t RESET_W0 = 32'd123456789;
  localparam word_t RESET_W1 = 32'd362436069;
  localparam word_t RESET_W2 = 32'd521288629;
  localparam word_t RESET_W3 = 32'd88675123;

  function automatic word_t rotl32(word_t v, int unsigned amt);
    return (v << amt) | (v >> (32 - amt));
  endfunction

  // xor/shift/rotate state update
  function automatic words_t advance(words_t s);
    word_t t;
    word_t w0;
    word_t w1;
    word_t w2;
    word_t w3;
    t  = s[1] << SHL_STATE;
    w2 = s[2] ^ s[0];
    w3 = s[3] ^ s[1];
    w1 = s[1] ^ w2;
    w0 = s[0] ^ w3;
    w2 = w2 ^ t;
    w3 = rotl32(w3, ROT_STATE);
    return {w3, w2, w1, w0};
  endfunction

endpackage

[src/xs128_mul.sv]
`timescale 1ns / 1ps
// Shared 32x32 multiplier, low half of the product, one register stage.
// Depends on xs128_pkg.
module xs128_mul (
  input  logic              clk,
  input  xs128_pkg::word_t  mul_a,
  input  xs128_pkg::word_t  mul_b,
  output xs128_pkg::word_t  mul_p
);
  import xs128_pkg::*;

  word_t p_r;
  word_t p_nxt;

  assign p_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign mul_p = p_r;

endmodule

[src/xs128_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer and state words of the generator; drives the shared multiplier.
// Depends on xs128_pkg and xs128_mul.
module xs128_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  xs128_pkg::word_t  in_seed_value,
  input  xs128_pkg::word_t  in_load_word0,
  input  xs128_pkg::word_t  in_load_word1,
  input  xs128_pkg::word_t  in_load_word2,
  input  xs128_pkg::word_t  in_load_word3,
  output xs128_pkg::res_t   res,
  input  logic              res_ready
);
  import xs128_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_GEN_B = 3'd1;
  localparam logic [2:0] ST_GEN_C = 3'd2;
  localparam logic [2:0] ST_SEED  = 3'd3;
  localparam logic [2:0] ST_RES   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  words_t     s_r;
  words_t     s_nxt;
  word_t      value_r;
  word_t      value_nxt;
  word_t      mul_a;
  word_t      mul_b;
  word_t      mul_p;
  word_t      seed_word;

  xs128_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  // product plus round index (1..4)
  assign seed_word = mul_p + {30'd0, cnt_r} + 32'd1;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    s_nxt     = s_r;
    value_nxt = value_r;
    mul_a     = s_r[1];
    mul_b     = GEN_MUL1;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_GEN: begin
              // multiply reads the old word 1; advance the state at once
              mul_a     = s_r[1];
              mul_b     = GEN_MUL1;
              s_nxt     = advance(s_r);
              state_nxt = ST_GEN_B;
            end
            MODE_SEED: begin
              mul_a     = SEED_MULT;
              mul_b     = in_seed_value ^ (in_seed_value >> SEED_SHR);
              cnt_nxt   = 2'd0;
              state_nxt = ST_SEED;
            end
            MODE_LOAD: begin
              s_nxt     = {in_load_word3, in_load_word2, in_load_word1, in_load_word0};
              value_nxt = '0;
              state_nxt = ST_RES;
            end
            default: begin
              value_nxt = '0;
              state_nxt = ST_RES;
            end
          endcase
        end
      end
      ST_GEN_B: begin
        mul_a     = rotl32(mul_p, ROT_OUT);
        mul_b     = GEN_MUL2;
        state_nxt = ST_GEN_C;
      end
      ST_GEN_C: begin
        value_nxt = mul_p;
        state_nxt = ST_RES;
      end
      ST_SEED: begin
        s_nxt[cnt_r] = seed_word;
        mul_a        = SEED_MULT;
        mul_b        = seed_word ^ (seed_word >> SEED_SHR);
        if (cnt_r == 2'd3) begin
          value_nxt = '0;
          state_nxt = ST_RES;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      ST_RES: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 2'd0;
      s_r     <= {RESET_W3, RESET_W2, RESET_W1, RESET_W0};
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      s_r     <= s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign res.valid = (state_r == ST_RES);
  assign res.value = value_r;
  assign res.words = s_r;

  a_gen_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && in_mode == MODE_GEN)
      |=> state_r == ST_GEN_B ##1 state_r == ST_GEN_C ##1 state_r == ST_RES)
    else $error("generate sequence broken");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && in_mode == MODE_LOAD)
      |=> (state_r == ST_RES && s_r[0] == $past(in_load_word0)
           && s_r[3] == $past(in_load_word3)))
    else $error("load did not reach state words");

  a_seed_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEED && cnt_r == 2'd3) |=> state_r == ST_RES)
    else $error("reseed did not finish after four rounds");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RES && !res_ready)
      |=> (state_r == ST_RES && $stable(s_r) && $stable(value_r)))
    else $error("pending result changed");

endmodule

[src/xoshiro128ss_generator_core.sv]
`timescale 1ns / 1ps
// xoshiro128** generator top level: sequencer plus output register.
// Depends on xs128_pkg and xs128_ctrl. An item takes two (generate) or four (reseed) chained
// passes through the one shared multiplier; a new item is accepted once the previous result
// has moved into the output register, which may still be waiting for out_ready.
// Synchronous active-low reset restores the four default state words and empties the output.
module xoshiro128ss_generator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  xs128_pkg::word_t  in_seed_value,
  input  xs128_pkg::word_t  in_load_word0,
  input  xs128_pkg::word_t  in_load_word1,
  input  xs128_pkg::word_t  in_load_word2,
  input  xs128_pkg::word_t  in_load_word3,
  output logic              out_valid,
  input  logic              out_ready,
  output xs128_pkg::word_t  out_random_value,
  output xs128_pkg::word_t  out_now_word0,
  output xs128_pkg::word_t  out_now_word1,
  output xs128_pkg::word_t  out_now_word2,
  output xs128_pkg::word_t  out_now_word3
);
  import xs128_pkg::*;

  res_t   res;
  logic   res_ready;
  logic   out_valid_r;
  logic   out_valid_nxt;
  word_t  value_r;
  words_t words_r;

  xs128_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_seed_value (in_seed_value),
    .in_load_word0 (in_load_word0),
    .in_load_word1 (in_load_word1),
    .in_load_word2 (in_load_word2),
    .in_load_word3 (in_load_word3),
    .res           (res),
    .res_ready     (res_ready)
  );

  // take a new result when the register is empty or its transfer completes
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      value_r <= res.value;
      words_r <= res.words;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = value_r;
  assign out_now_word0    = words_r[0];
  assign out_now_word1    = words_r[1];
  assign out_now_word2    = words_r[2];
  assign out_now_word3    = words_r[3];

endmodule

[sim/xs128_output_checker.sv]
`timescale 1ns / 1ps
// Result checker for xoshiro128ss_generator_core: keeps its own copy of the generator
// words, predicts each result at the input transfer and compares at the output transfer.
// Depends on xs128_pkg for word types and the default state words.
module xs128_output_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_mode,
  input  xs128_pkg::word_t  in_seed_value,
  input  xs128_pkg::word_t  in_load_word0,
  input  xs128_pkg::word_t  in_load_word1,
  input  xs128_pkg::word_t  in_load_word2,
  input  xs128_pkg::word_t  in_load_word3,
  input  logic              out_valid,
  input  logic              out_ready,
  input  xs128_pkg::word_t  out_random_value,
  input  xs128_pkg::word_t  out_now_word0,
  input  xs128_pkg::word_t  out_now_word1,
  input  xs128_pkg::word_t  out_now_word2,
  input  xs128_pkg::word_t  out_now_word3,
  output int                fail_count,
  output int                pending,
  output int                checked
);
  import xs128_pkg::*;

  typedef struct packed {
    word_t  value;
    words_t words;
  } gen_result_t;

  words_t      gen_words;
  gen_result_t next_results_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  // Apply one item to the local generator words and return the result it gives
  function automatic gen_result_t step_generator(logic [1:0] mode, word_t seed,
                                                 words_t loaded);
    gen_result_t res;
    word_t       prod;
    word_t       spun;
    word_t       lifted;
    word_t       x0;
    word_t       x1;
    word_t       x2;
    word_t       x3;
    res.value = '0;
    case (mode)
      MODE_GEN: begin
        prod      = gen_words[1] * 32'd5;
        spun      = {prod[24:0], prod[31:25]};
        res.value = spun * 32'd9;
        lifted    = gen_words[1] << 9;
        x2        = gen_words[2] ^ gen_words[0];
        x3        = gen_words[3] ^ gen_words[1];
        x1        = gen_words[1] ^ x2;
        x0        = gen_words[0] ^ x3;
        x2        = x2 ^ lifted;
        x3        = {x3[20:0], x3[31:21]};
        gen_words = {x3, x2, x1, x0};
      end
      MODE_SEED: begin
        for (int k = 0; k < 4; k++) begin
          seed         = SEED_MULT * (seed ^ (seed >> SEED_SHR)) + word_t'(k + 1);
          gen_words[k] = seed;
        end
      end
      MODE_LOAD: begin
        gen_words = loaded;
      end
      default: begin
        // undefined mode: hold the words
      end
    endcase
    res.words = gen_words;
    return res;
  endfunction

  task automatic check_field(string name, word_t want, word_t got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    gen_result_t want;
    if (!rst_n) begin
      gen_words = {RESET_W3, RESET_W2, RESET_W1, RESET_W0};
      next_results_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (next_results_q.size() == 0) begin
          $error("result transfer with nothing outstanding: random_value %h",
                 out_random_value);
          fail_count++;
        end else begin
          want = next_results_q.pop_front();
          checked++;
          check_field("random_value", want.value,    out_random_value);
          check_field("now_word0",    want.words[0], out_now_word0);
          check_field("now_word1",    want.words[1], out_now_word1);
          check_field("now_word2",    want.words[2], out_now_word2);
          check_field("now_word3",    want.words[3], out_now_word3);
        end
      end
      if (in_valid && in_ready)
        next_results_q.push_back(step_generator(in_mode, in_seed_value,
          {in_load_word3, in_load_word2, in_load_word1, in_load_word0}));
    end
    pending = next_results_q.size();
  end

endmodule

[sim/tb_xoshiro128ss_generator_core.sv]
`timescale 1ns / 1ps
// Testbench top for xoshiro128ss_generator_core: clock, reset, item and back-pressure
// stimulus, watchdog and verdict. Depends on xs128_pkg and xs128_output_checker.
module tb_xoshiro128ss_generator_core;
  import xs128_pkg::*;

  localparam logic [1:0] MODE_NONE      = 2'd3;
  localparam int         RANDOM_ITEMS   = 1180;
  localparam int         LONG_HOLD      = 80;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_mode;
  word_t      in_seed_value;
  word_t      in_load_word0;
  word_t      in_load_word1;
  word_t      in_load_word2;
  word_t      in_load_word3;
  logic       out_valid;
  logic       out_ready;
  word_t      out_random_value;
  word_t      out_now_word0;
  word_t      out_now_word1;
  word_t      out_now_word2;
  word_t      out_now_word3;

  int fail_count;
  int pending;
  int checked;
  int idle_cycles;
  int mode_counts [4];
  bit calm;
  bit long_hold;
  bit tx_quiet;
  bit rx_quiet;

  xoshiro128ss_generator_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_seed_value    (in_seed_value),
    .in_load_word0    (in_load_word0),
    .in_load_word1    (in_load_word1),
    .in_load_word2    (in_load_word2),
    .in_load_word3    (in_load_word3),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value),
    .out_now_word0    (out_now_word0),
    .out_now_word1    (out_now_word1),
    .out_now_word2    (out_now_word2),
    .out_now_word3    (out_now_word3)
  );

  xs128_output_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_seed_value    (in_seed_value),
    .in_load_word0    (in_load_word0),
    .in_load_word1    (in_load_word1),
    .in_load_word2    (in_load_word2),
    .in_load_word3    (in_load_word3),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value),
    .out_now_word0    (out_now_word0),
    .out_now_word1    (out_now_word1),
    .out_now_word2    (out_now_word2),
    .out_now_word3    (out_now_word3),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Entered and left at a falling edge; returns once the item has been transferred
  task automatic offer(logic [1:0] mode, word_t seed, word_t w0, word_t w1, word_t w2,
                       word_t w3);
    if ($urandom_range(0, 99) == 0)
      tx_quiet = ~tx_quiet;
    if (!calm && !tx_quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_seed_value <= seed;
    in_load_word0 <= w0;
    in_load_word1 <= w1;
    in_load_word2 <= w2;
    in_load_word3 <= w3;
    do @(posedge clk); while (!in_ready);
    mode_counts[mode]++;
    @(negedge clk);
  endtask

  task automatic offer_gen();
    offer(MODE_GEN, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic offer_seed(word_t seed);
    offer(MODE_SEED, seed, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic offer_load(word_t w0, word_t w1, word_t w2, word_t w3);
    offer(MODE_LOAD, $urandom, w0, w1, w2, w3);
  endtask

  // Hold the input off until every predicted result has come back
  task automatic drain_all();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic random_item();
    int    pick;
    word_t seed;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      case ($urandom_range(0, 7))
        0:       seed = '0;
        1:       seed = '1;
        default: seed = $urandom;
      endcase
      offer_seed(seed);
    end else if (pick < 24) begin
      if ($urandom_range(0, 9) == 0)
        offer_load('0, '0, '0, '0);
      else if ($urandom_range(0, 9) == 0)
        offer_load('1, '1, '1, '1);
      else
        offer_load($urandom, $urandom, $urandom, $urandom);
    end else if (pick < 30) begin
      offer(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      offer_gen();
    end
  endtask

  // Receiver: random hold-offs, quiet stretches and one long hold when asked
  initial begin
    out_ready = 1'b0;
    rx_quiet  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 149) == 0)
        rx_quiet = ~rx_quiet;
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && !rx_quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
               idle_cycles, pending);
      $display("** xoshiro128ss_generator_core: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_GEN;
    in_seed_value = '0;
    in_load_word0 = '0;
    in_load_word1 = '0;
    in_load_word2 = '0;
    in_load_word3 = '0;
    calm          = 1'b0;
    long_hold     = 1'b0;
    tx_quiet      = 1'b0;
    idle_cycles   = 0;
    foreach (mode_counts[m])
      mode_counts[m] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: default words, undefined mode, seed extremes, all-zero and all-one state
    offer_gen();
    offer_gen();
    offer_gen();
    offer(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
    offer_seed('0);
    offer_gen();
    offer_seed('1);
    offer_gen();
    offer_seed(32'hC000_0000);
    offer_gen();
    offer_load('0, '0, '0, '0);
    offer_gen();
    offer_gen();
    offer_load('1, '1, '1, '1);
    offer_gen();
    offer_gen();
    offer_load(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
    offer_gen();
    offer(MODE_NONE, '1, '1, '1, '1, '1);
    offer_gen();
    offer_load('0, '1, '0, '0);
    offer_gen();
    drain_all();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 400)
        long_hold = 1'b1;
      if (i == 800)
        drain_all();
      if (i == RANDOM_ITEMS - 150)
        calm = 1'b1;
      random_item();
    end

    drain_all();
    repeat (12) @(posedge clk);
    $display("Covered %0d generate, %0d reseed, %0d load and %0d undefined-mode transfers;",
             mode_counts[MODE_GEN], mode_counts[MODE_SEED], mode_counts[MODE_LOAD],
             mode_counts[MODE_NONE]);
    $display("%0d results compared under random stalls, a long output hold and a drain.",
             checked);
    if (fail_count == 0 && pending == 0)
      $display("** xoshiro128ss_generator_core: PASSED **");
    else
      $display("** xoshiro128ss_generator_core: FAILED **");
    $finish;
  end

endmodule

[sim.f]
src/xs128_pkg.sv
src/xs128_mul.sv
src/xs128_ctrl.sv
src/xoshiro128ss_generator_core.sv
sim/xs128_output_checker.sv
sim/tb_xoshiro128ss_generator_core.sv
